/* rtl/prq_pkg.sv */
`default_nettype none

package prq_pkg;

  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_SAVED   = 2'd1;
  localparam logic [1:0] MODE_CLEAN   = 2'd2;

  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_WREMOVED = 3'd3;
  localparam logic [2:0] ST_RREMOVED = 3'd4;
  localparam logic [2:0] ST_NONE     = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] page;
    logic        is_write;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] queue_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic rm_write;
    logic shift;
    logic append;
    logic drop;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic wr_found;
    logic rd_found;
    logic full;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/prq_ram.sv */
`default_nettype none

module prq_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/prq_datapath.sv */
`default_nettype none

module prq_datapath
  import prq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_t        in_data_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  output logic [4:0]      queue_count_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned EntW = PAGE_BITS + 1;

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      ptr_q, ptr_d;
  logic                 cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]      cmp_idx_q, cmp_idx_d;
  logic                 wr_found_q, wr_found_d;
  logic                 rd_found_q, rd_found_d;
  logic [IdxW-1:0]      wr_idx_q, wr_idx_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 write_q, write_d;

  logic                 issue;
  logic                 hit;
  logic [IdxW-1:0]      sel_idx;
  logic [EntW-1:0]      rd_data;
  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr;
  logic [EntW-1:0]      ram_wdata;

  assign issue   = (cmd_i.scan | cmd_i.shift) & (ptr_q < cnt_q);
  assign hit     = cmp_vld_q & cmd_i.scan & (rd_data[PAGE_BITS-1:0] == page_q);
  assign sel_idx = cmd_i.rm_write ? wr_idx_q : rd_idx_q;

  always_comb begin
    cnt_d      = cnt_q;
    ptr_d      = ptr_q;
    cmp_vld_d  = issue;
    cmp_idx_d  = issue ? ptr_q[IdxW-1:0] : cmp_idx_q;
    wr_found_d = wr_found_q;
    rd_found_d = rd_found_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    page_d     = page_q;
    write_d    = write_q;

    if (cmd_i.load) begin
      ptr_d      = '0;
      wr_found_d = 1'b0;
      rd_found_d = 1'b0;
      page_d     = PAGE_BITS'(in_data_i.page);
      write_d    = in_data_i.is_write;
    end else if (cmd_i.shift_init) begin
      ptr_d = CntW'(sel_idx) + CntW'(1);
    end else if (issue) begin
      ptr_d = ptr_q + CntW'(1);
    end

    // oldest write and oldest read for the page, found in one pass
    if (hit && rd_data[PAGE_BITS] && !wr_found_q) begin
      wr_found_d = 1'b1;
      wr_idx_d   = cmp_idx_q;
    end
    if (hit && !rd_data[PAGE_BITS] && !rd_found_q) begin
      rd_found_d = 1'b1;
      rd_idx_d   = cmp_idx_q;
    end

    if (cmd_i.append) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.drop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  // shift moves entry i+1 into slot i, one transfer per cycle
  always_comb begin
    ram_we    = cmd_i.append | (cmd_i.shift & cmp_vld_q);
    ram_waddr = cmd_i.append ? cnt_q[IdxW-1:0] : (cmp_idx_q - IdxW'(1));
    ram_wdata = cmd_i.append ? {write_q, page_q} : rd_data;
  end

  prq_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      wr_found_q <= 1'b0;
      rd_found_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      ptr_q      <= ptr_d;
      cmp_vld_q  <= cmp_vld_d;
      wr_found_q <= wr_found_d;
      rd_found_q <= rd_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    wr_idx_q  <= wr_idx_d;
    rd_idx_q  <= rd_idx_d;
    page_q    <= page_d;
    write_q   <= write_d;
  end

  always_comb begin
    sts_o.scan_done  = cmd_i.scan & ~issue & ~cmp_vld_q;
    sts_o.shift_done = cmd_i.shift & ~issue & ~cmp_vld_q;
    sts_o.wr_found   = wr_found_q;
    sts_o.rd_found   = rd_found_q;
    sts_o.full       = (cnt_q == CntW'(DEPTH));
  end

  assign queue_count_o = 5'(cnt_q);

endmodule

`default_nettype wire

/* rtl/prq_ctrl.sv */
`default_nettype none

module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_mode_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      status_o,
  output cmd_t            cmd_o,
  input  wire sts_t       sts_i
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_RESULT = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] mode_q, mode_d;
  logic [2:0] status_q, status_d;

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    status_d = status_q;
    cmd_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mode_d     = in_mode_i;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d  = S_RESULT;
          status_d = ST_NONE;
          case (mode_q)
            MODE_ENQUEUE: begin
              if (sts_i.wr_found) begin
                status_d = ST_PENDING;
              end else if (sts_i.full) begin
                status_d = ST_FULL;
              end else begin
                cmd_o.append = 1'b1;
                status_d     = ST_ENQUEUED;
              end
            end
            MODE_SAVED: begin
              if (sts_i.wr_found) begin
                cmd_o.shift_init = 1'b1;
                cmd_o.rm_write   = 1'b1;
                status_d         = ST_WREMOVED;
                state_d          = S_SHIFT;
              end else if (sts_i.rd_found) begin
                cmd_o.shift_init = 1'b1;
                status_d         = ST_RREMOVED;
                state_d          = S_SHIFT;
              end
            end
            MODE_CLEAN: begin
              if (sts_i.rd_found) begin
                cmd_o.shift_init = 1'b1;
                status_d         = ST_RREMOVED;
                state_d          = S_SHIFT;
              end
            end
            default: begin
              status_d = ST_NONE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          cmd_o.drop = 1'b1;
          state_d    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    status_q <= status_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESULT);
  assign status_o    = status_q;

endmodule

`default_nettype wire

/* rtl/page_request_queue_top.sv */
// Ordered queue of page requests (page number plus read/write mark), oldest
// first. One transfer in gives exactly one transfer out: status and the queue
// count after the step. Items are handled one at a time. Each item makes one
// scan over the N queued entries, finding the oldest write and oldest read for
// the page; a release then closes the gap by moving the later entries down one
// slot per cycle. The time an item takes is set by the single read port of the
// entry RAM. The queue comes out of reset empty; no clearing pass is needed.
`default_nettype none

module page_request_queue_top
  import prq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [2:0] status;
  logic [4:0] queue_count;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  prq_datapath #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (in_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .queue_count_o (queue_count)
  );

  assign out_data_o.status      = status;
  assign out_data_o.queue_count = queue_count;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o && out_valid_o))
    else $error("input transfer while a result is pending");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= ST_NONE))
    else $error("status code out of range");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_FULL) |-> (out_data_o.queue_count == 5'(DEPTH)))
    else $error("full status with queue not full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((DEPTH > 31) || (32'(out_data_o.queue_count) <= DEPTH)))
    else $error("queue count above depth");

endmodule

`default_nettype wire
